/* src/msf_pkg.sv */
// ============================================================================
// msf_pkg: shared types, constants and tables for the face segment pipeline
// Holds the word formats, the fixed-point widths, the edge pair table and
// the corner offset table used by the prep and placement stages.
// ============================================================================
package msf_pkg;

    // Fixed-point geometry of the result coordinates.
    localparam int COORD_BITS = 8;
    localparam int FRAC_BITS  = 8;
    localparam int VAL_BITS   = 8;
    localparam int BASE_BITS  = COORD_BITS + 1;
    localparam int OUT_BITS   = COORD_BITS + FRAC_BITS + 1;
    localparam int QUO_BITS   = FRAC_BITS + 1;

    // Cell index mask applied to the 8-bit input position fields.
    localparam logic [7:0] CELL_MASK = 8'((1 << COORD_BITS) - 1);

    // Reset value of the iso level register.
    localparam logic [VAL_BITS-1:0] ISO_RESET = VAL_BITS'(128);

    // Face plane codes.
    localparam logic [1:0] PLANE_XY = 2'd0;
    localparam logic [1:0] PLANE_YZ = 2'd1;
    localparam logic [1:0] PLANE_ZX = 2'd2;

    // Direction of a coordinate along a face edge.
    typedef enum logic [1:0] {
        STEP_HOLD,
        STEP_UP,
        STEP_DOWN
    } step_t;

    // Input word: one cell face.
    typedef struct packed {
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic [7:0] cell_z;
        logic [1:0] face_plane;
        logic [7:0] corner_value_0;
        logic [7:0] corner_value_1;
        logic [7:0] corner_value_2;
        logic [7:0] corner_value_3;
    } in_word_t;

    // Output word: one line segment in Q9.8 grid units.
    typedef struct packed {
        logic [OUT_BITS-1:0] start_x;
        logic [OUT_BITS-1:0] start_y;
        logic [OUT_BITS-1:0] start_z;
        logic [OUT_BITS-1:0] end_x;
        logic [OUT_BITS-1:0] end_y;
        logic [OUT_BITS-1:0] end_z;
    } out_word_t;

    // Work carried for one edge through the divider stages.
    typedef struct packed {
        logic [2:0][BASE_BITS-1:0] base;
        step_t [2:0]               step;
        logic [VAL_BITS-1:0]       den;
        logic [VAL_BITS-1:0]       rem;
        logic [QUO_BITS-1:0]       quo;
    } edge_work_t;

    // Work carried for one segment: both of its edges.
    typedef struct packed {
        edge_work_t edge_a;
        edge_work_t edge_b;
    } seg_work_t;

    // Result of the edge pair lookup.
    typedef struct packed {
        logic       ok;
        logic [1:0] e0;
        logic [1:0] e1;
    } edge_sel_t;

    // Single-segment table: mask of inside corners to the pair of edges.
    function automatic edge_sel_t edge_pair(input logic [3:0] mask);
        edge_sel_t s;
        s = '{ok: 1'b1, e0: 2'd0, e1: 2'd0};
        case (mask)
            4'b0001, 4'b1110: begin s.e0 = 2'd0; s.e1 = 2'd3; end
            4'b0010, 4'b1101: begin s.e0 = 2'd0; s.e1 = 2'd1; end
            4'b0011, 4'b1100: begin s.e0 = 2'd1; s.e1 = 2'd3; end
            4'b0100, 4'b1011: begin s.e0 = 2'd1; s.e1 = 2'd2; end
            4'b0110, 4'b1001: begin s.e0 = 2'd0; s.e1 = 2'd2; end
            4'b0111, 4'b1000: begin s.e0 = 2'd2; s.e1 = 2'd3; end
            default:          s.ok = 1'b0;
        endcase
        return s;
    endfunction

    // Corner offset from the cell origin, bit 0 is x, bit 1 y, bit 2 z.
    function automatic logic [2:0] corner_offset(input logic [1:0] plane,
                                                 input logic [1:0] corner);
        logic [2:0] d;
        d = 3'b000;
        case (plane)
            PLANE_XY:
            begin
                case (corner)
                    2'd1:    d = 3'b001;
                    2'd2:    d = 3'b011;
                    2'd3:    d = 3'b010;
                    default: d = 3'b000;
                endcase
            end
            PLANE_YZ:
            begin
                case (corner)
                    2'd1:    d = 3'b010;
                    2'd2:    d = 3'b110;
                    2'd3:    d = 3'b100;
                    default: d = 3'b000;
                endcase
            end
            PLANE_ZX:
            begin
                case (corner)
                    2'd1:    d = 3'b100;
                    2'd2:    d = 3'b101;
                    2'd3:    d = 3'b001;
                    default: d = 3'b000;
                endcase
            end
            default: d = 3'b000;
        endcase
        return d;
    endfunction

endpackage

/* src/msf_prep.sv */
// ============================================================================
// msf_prep: classify a face and set up the division for each of its edges
// Builds the inside mask, looks up the edge pair, drops faces with no
// segment, and registers per-edge base points, directions and operands.
// ============================================================================
module msf_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          up_valid,
    output logic                          up_ready,
    input  msf_pkg::in_word_t             in_word,
    input  logic [msf_pkg::VAL_BITS-1:0]  iso_level,
    output logic                          dn_valid,
    input  logic                          dn_ready,
    output msf_pkg::seg_work_t            dn_work
);
    import msf_pkg::*;

    logic                            valid_reg;
    logic                            valid_next;
    seg_work_t                       work_reg;
    seg_work_t                       work_next;
    logic [3:0][VAL_BITS-1:0]        val;
    logic [2:0][BASE_BITS-1:0]       cell_pos;
    logic [3:0]                      mask;
    edge_sel_t                       sel;
    logic                            has_seg;

    // Operands and geometry of one edge of the face.
    function automatic edge_work_t make_edge(input logic [2:0][BASE_BITS-1:0] c,
                                             input logic [3:0][VAL_BITS-1:0] v,
                                             input logic [1:0] plane,
                                             input logic [1:0] e,
                                             input logic [VAL_BITS-1:0] iso);
        logic [1:0]          c1;
        logic [VAL_BITS-1:0] a;
        logic [VAL_BITS-1:0] b;
        logic [VAL_BITS-1:0] num;
        logic [VAL_BITS-1:0] den;
        logic [2:0]          d0;
        logic [2:0]          d1;
        edge_work_t          w;
        c1 = e + 2'd1;
        a  = v[e];
        b  = v[c1];
        if (a > iso)
        begin
            num = a - iso;
            den = (a > b) ? a - b : '0;
        end
        else
        begin
            num = iso - a;
            den = (b > a) ? b - a : '0;
        end
        d0 = corner_offset(plane, e);
        d1 = corner_offset(plane, c1);
        w  = '0;
        for (int ax = 0; ax < 3; ax++)
        begin
            w.base[ax] = c[ax] + {{COORD_BITS{1'b0}}, d0[ax]};
            if (d1[ax] && !d0[ax])
                w.step[ax] = STEP_UP;
            else if (!d1[ax] && d0[ax])
                w.step[ax] = STEP_DOWN;
            else
                w.step[ax] = STEP_HOLD;
        end
        // A zero span gives a zero fraction: divide zero by one.
        if (den == '0)
        begin
            w.den = VAL_BITS'(1);
            w.rem = '0;
            w.quo = '0;
        end
        else if (num >= den)
        begin
            w.den = den;
            w.rem = num - den;
            w.quo = QUO_BITS'(1);
        end
        else
        begin
            w.den = den;
            w.rem = num;
            w.quo = '0;
        end
        return w;
    endfunction

    // Inside mask and edge pair lookup.
    always_comb
    begin
        val[0]  = in_word.corner_value_0;
        val[1]  = in_word.corner_value_1;
        val[2]  = in_word.corner_value_2;
        val[3]  = in_word.corner_value_3;
        cell_pos[0] = BASE_BITS'(in_word.cell_x & CELL_MASK);
        cell_pos[1] = BASE_BITS'(in_word.cell_y & CELL_MASK);
        cell_pos[2] = BASE_BITS'(in_word.cell_z & CELL_MASK);
        for (int k = 0; k < 4; k++)
        begin
            mask[k] = val[k] > iso_level;
        end
        sel     = edge_pair(mask);
        has_seg = sel.ok && (in_word.face_plane <= PLANE_ZX);
        work_next.edge_a = make_edge(cell_pos, val, in_word.face_plane, sel.e0, iso_level);
        work_next.edge_b = make_edge(cell_pos, val, in_word.face_plane, sel.e1, iso_level);
    end

    // Stage handshake: load when empty or when the next stage takes the word.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? (up_valid && has_seg) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            work_reg <= work_next;
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

`ifndef SYNTH
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (work_reg.edge_a.den != '0) && (work_reg.edge_b.den != '0))
        else $error("msf_prep: divisor of zero reached the divider");
`endif

endmodule

/* src/msf_div_stage.sv */
// ============================================================================
// msf_div_stage: one restoring-division step for both edges of a segment
// Doubles the partial remainder, compares it with the span and shifts one
// fraction bit into each quotient.
// ============================================================================
module msf_div_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  msf_pkg::seg_work_t up_work,
    output logic               dn_valid,
    input  logic               dn_ready,
    output msf_pkg::seg_work_t dn_work
);
    import msf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    seg_work_t work_reg;
    seg_work_t work_next;

    // One quotient bit of one edge.
    function automatic edge_work_t div_step(input edge_work_t w);
        logic [VAL_BITS:0] twice;
        logic              ge;
        edge_work_t        r;
        r     = w;
        twice = {w.rem, 1'b0};
        ge    = twice >= {1'b0, w.den};
        r.rem = ge ? VAL_BITS'(twice - {1'b0, w.den}) : twice[VAL_BITS-1:0];
        r.quo = {w.quo[QUO_BITS-2:0], ge};
        return r;
    endfunction

    // Both edges step in parallel.
    always_comb
    begin
        work_next.edge_a = div_step(up_work.edge_a);
        work_next.edge_b = div_step(up_work.edge_b);
    end

    // Stage handshake.
    assign up_ready   = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            work_reg <= work_next;
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (work_reg.edge_a.rem < work_reg.edge_a.den) &&
                      (work_reg.edge_b.rem < work_reg.edge_b.den))
        else $error("msf_div_stage: partial remainder not below divisor");
`endif

endmodule

/* src/msf_place.sv */
// ============================================================================
// msf_place: place the crossing points and hold the output word
// Adds or subtracts each fraction from the edge base point per axis and
// registers the segment for the output channel.
// ============================================================================
module msf_place (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  msf_pkg::seg_work_t up_work,
    output logic               out_valid,
    input  logic               out_stall,
    output msf_pkg::out_word_t out_word
);
    import msf_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;
    out_word_t word_next;

    // Coordinate of a crossing on one axis, wrapped to the output width.
    function automatic logic [OUT_BITS-1:0] place(input logic [BASE_BITS-1:0] base,
                                                  input step_t step,
                                                  input logic [QUO_BITS-1:0] quo);
        logic [OUT_BITS-1:0] p;
        logic [OUT_BITS-1:0] f;
        p = {base, {FRAC_BITS{1'b0}}};
        f = OUT_BITS'(quo);
        case (step)
            STEP_UP:   p = p + f;
            STEP_DOWN: p = p - f;
            default:   p = p;
        endcase
        return p;
    endfunction

    // Both endpoints on all three axes.
    always_comb
    begin
        word_next.start_x = place(up_work.edge_a.base[0], up_work.edge_a.step[0],
                                  up_work.edge_a.quo);
        word_next.start_y = place(up_work.edge_a.base[1], up_work.edge_a.step[1],
                                  up_work.edge_a.quo);
        word_next.start_z = place(up_work.edge_a.base[2], up_work.edge_a.step[2],
                                  up_work.edge_a.quo);
        word_next.end_x   = place(up_work.edge_b.base[0], up_work.edge_b.step[0],
                                  up_work.edge_b.quo);
        word_next.end_y   = place(up_work.edge_b.base[1], up_work.edge_b.step[1],
                                  up_work.edge_b.quo);
        word_next.end_z   = place(up_work.edge_b.base[2], up_work.edge_b.step[2],
                                  up_work.edge_b.quo);
    end

    // Output register: holds its word while the receiver stalls.
    assign up_ready   = !valid_reg || !out_stall;
    assign valid_next = up_ready ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            word_reg <= word_next;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* src/marching_squares_face_segment.sv */
// ============================================================================
// marching_squares_face_segment: contour segment of one voxel-cell face
// Path: prep register, divider stages, placement register; results in Q9.8.
// Throughput: one face per cycle while out_stall is low; one divider stage per fraction bit.
// Faces with no segment are dropped in the first stage; empty slots close up.
// Reset clears all valid bits and sets the iso level to 128; no clearing pass.
// ============================================================================
module marching_squares_face_segment (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  msf_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output msf_pkg::out_word_t            out_word,
    input  logic                          cfg_write,
    input  logic [msf_pkg::VAL_BITS-1:0]  cfg_data
);
    import msf_pkg::*;

    logic [VAL_BITS-1:0] iso_level_reg;
    logic [VAL_BITS-1:0] iso_level_next;
    logic                prep_ready;
    logic [FRAC_BITS:0]  stage_valid;
    logic [FRAC_BITS:0]  stage_ready;
    seg_work_t           stage_work [FRAC_BITS+1];

    // Iso level register.
    assign iso_level_next = cfg_write ? cfg_data : iso_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iso_level_reg <= ISO_RESET;
        else
            iso_level_reg <= iso_level_next;
    end

    // Classification and operand setup.
    msf_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (in_valid),
        .up_ready  (prep_ready),
        .in_word   (in_word),
        .iso_level (iso_level_reg),
        .dn_valid  (stage_valid[0]),
        .dn_ready  (stage_ready[0]),
        .dn_work   (stage_work[0])
    );

    assign in_stall = !prep_ready;

    // Division pipeline: one fraction bit per stage.
    for (genvar i = 0; i < FRAC_BITS; i++)
    begin : g_div
        msf_div_stage u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (stage_valid[i]),
            .up_ready (stage_ready[i]),
            .up_work  (stage_work[i]),
            .dn_valid (stage_valid[i+1]),
            .dn_ready (stage_ready[i+1]),
            .dn_work  (stage_work[i+1])
        );
    end

    // Endpoint placement and output register.
    msf_place u_place (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (stage_valid[FRAC_BITS]),
        .up_ready  (stage_ready[FRAC_BITS]),
        .up_work   (stage_work[FRAC_BITS]),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

`ifndef SYNTH
    a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> iso_level_reg == $past(cfg_data))
        else $error("top: iso level write was not taken");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> stage_valid[0] && !stage_ready[0])
        else $error("top: input stalled while the first stage could advance");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(stage_valid[FRAC_BITS]))
        else $error("top: output word appeared without a word in the last stage");
`endif

endmodule

/* dv/marching_squares_face_segment_test.sv */
// ============================================================================
// marching_squares_face_segment_test: self-checking bench for the face segment
// Drives cell faces through the block with random idling on both sides and
// checks every segment word, field by field, against an in-bench prediction
// built from the corner densities, the face plane and the current iso level.
// ============================================================================
`timescale 1ns / 1ps

module marching_squares_face_segment_test;

    import msf_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 11;
    // Pipeline depth plus margin, used before iso writes and at the end.
    localparam int DRAIN_CYCLES = FRAC_BITS + 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int TIMEOUT_NS   = 4_000_000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    in_word_t  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_word;
    logic      cfg_write = 1'b0;
    logic [VAL_BITS-1:0] cfg_data = '0;

    // Bench copy of the iso level register.
    logic [7:0] iso_model = ISO_RESET;

    // Segments still owed by the block, oldest first.
    out_word_t segments_due [$];
    int        mismatch_count = 0;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_active = 1'b0;
    event hold_start;

    string seg_field_name [6] = '{"end_z", "end_y", "end_x",
                                  "start_z", "start_y", "start_x"};

    marching_squares_face_segment dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Run limit.
    initial
    begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Offset of a face corner along one axis. The plane number names the
    // axis the face runs along first; the next axis is the one it runs along second.
    function automatic int corner_shift(input int plane, input int corner, input int ax);
        logic [1:0] c;
        c = 2'(corner);
        if (ax == plane)
            return int'(c[0] ^ c[1]);
        if (ax == (plane + 1) % 3)
            return int'(c[1]);
        return 0;
    endfunction

    // Edge pair of the single-segment table. Complementary masks share a
    // pair, so the mask is folded onto its half with corner 3 outside.
    function automatic bit segment_edges(input logic [3:0] above,
                                         output int first, output int second);
        logic [3:0] folded;
        folded = above[3] ? ~above : above;
        first = 0;
        second = 0;
        case (folded)
            4'd1: begin first = 0; second = 3; end
            4'd2: begin first = 0; second = 1; end
            4'd3: begin first = 1; second = 3; end
            4'd4: begin first = 1; second = 2; end
            4'd6: begin first = 0; second = 2; end
            4'd7: begin first = 2; second = 3; end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Truncated crossing fraction (iso - a) / (b - a) with FRAC_BITS fraction bits.
    function automatic int crossing_step(input int a, input int b, input int level);
        int num;
        int den;
        if (a > level)
        begin
            num = a - level;
            den = (a > b) ? a - b : 0;
        end
        else
        begin
            num = level - a;
            den = (b > a) ? b - a : 0;
        end
        if (den == 0)
            return 0;
        return (num << FRAC_BITS) / den;
    endfunction

    // Crossing point on one face edge, x in entry 0, y in 1, z in 2.
    function automatic logic [2:0][OUT_BITS-1:0] crossing_point(input in_word_t w,
                                                              input int e);
        logic [3:0][7:0] corner;
        logic [2:0][7:0] origin;
        logic [2:0][OUT_BITS-1:0] pt;
        int c0;
        int c1;
        int f;
        int d0;
        int d1;
        int pos;
        corner = {w.corner_value_3, w.corner_value_2, w.corner_value_1, w.corner_value_0};
        origin = {w.cell_z, w.cell_y, w.cell_x};
        c0 = e;
        c1 = (e + 1) % 4;
        f = crossing_step(corner[c0], corner[c1], iso_model);
        for (int ax = 0; ax < 3; ax++)
        begin
            d0 = corner_shift(w.face_plane, c0, ax);
            d1 = corner_shift(w.face_plane, c1, ax);
            pos = ((int'(origin[ax]) & ((1 << COORD_BITS) - 1)) + d0) << FRAC_BITS;
            if (d1 > d0)
                pos = pos + f;
            else if (d1 < d0)
                pos = pos - f;
            pt[ax] = OUT_BITS'(pos);
        end
        return pt;
    endfunction

    // Segment a face produces, if any.
    function automatic bit predict_segment(input in_word_t w, output out_word_t seg);
        logic [3:0][7:0] corner;
        logic [3:0] above;
        logic [2:0][OUT_BITS-1:0] p0;
        logic [2:0][OUT_BITS-1:0] p1;
        int first;
        int second;
        corner = {w.corner_value_3, w.corner_value_2, w.corner_value_1, w.corner_value_0};
        seg = '0;
        for (int k = 0; k < 4; k++)
            above[k] = corner[k] > iso_model;
        if (w.face_plane > PLANE_ZX)
            return 1'b0;
        if (!segment_edges(above, first, second))
            return 1'b0;
        p0 = crossing_point(w, first);
        p1 = crossing_point(w, second);
        seg.start_x = p0[0];
        seg.start_y = p0[1];
        seg.start_z = p0[2];
        seg.end_x   = p1[0];
        seg.end_y   = p1[1];
        seg.end_z   = p1[2];
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Checks each accepted segment word and chooses the next stall.
    always @(posedge clk)
    begin : segment_check
        logic [5:0][OUT_BITS-1:0] want;
        logic [5:0][OUT_BITS-1:0] got;
        if (rst_n && out_valid && !out_stall)
        begin
            if (segments_due.size() == 0)
            begin
                $display("%0t: unexpected segment word %h", $time, out_word);
                mismatch_count++;
            end
            else
            begin
                want = segments_due.pop_front();
                got = out_word;
                for (int i = 0; i < 6; i++)
                begin
                    if (got[i] !== want[i])
                    begin
                        $display("%0t: %s expected %0d actual %0d", $time,
                                 seg_field_name[i], want[i], got[i]);
                        mismatch_count++;
                    end
                end
            end
        end
        out_stall <= hold_active || ($urandom_range(99) < recv_stall_pct);
    end

    // Long receiver hold-off, counted here once requested.
    initial
    begin
        forever
        begin
            @(hold_start);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one face word, with random idle cycles ahead of it, and records
    // its segment once the block takes it. Valid stays high on return.
    task automatic send_face(input in_word_t w);
        out_word_t seg;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (predict_segment(w, seg))
            segments_due.push_back(seg);
    endtask

    // Stops offering and waits until the block has nothing left in flight.
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (segments_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the iso level; only called while the block is idle.
    task automatic set_iso(input logic [7:0] level);
        cfg_write <= 1'b1;
        cfg_data <= level;
        @(posedge clk);
        cfg_write <= 1'b0;
        iso_model = level;
        @(posedge clk);
    endtask

    function automatic in_word_t make_face(input logic [7:0] x, input logic [7:0] y,
                                           input logic [7:0] z, input logic [1:0] plane,
                                           input logic [7:0] v0, input logic [7:0] v1,
                                           input logic [7:0] v2, input logic [7:0] v3);
        in_word_t w;
        w.cell_x = x;
        w.cell_y = y;
        w.cell_z = z;
        w.face_plane = plane;
        w.corner_value_0 = v0;
        w.corner_value_1 = v1;
        w.corner_value_2 = v2;
        w.corner_value_3 = v3;
        return w;
    endfunction

    // Mostly faces that cross the iso level, the rest uniform, saddle,
    // plane three, or corners sitting on and around the level.
    function automatic in_word_t random_face();
        logic [3:0][7:0] v;
        logic [3:0] above;
        logic [1:0] plane;
        int pick;
        pick = $urandom_range(99);
        plane = 2'($urandom_range(2));
        if (pick < 80 && iso_model != 8'd255)
        begin
            above = 4'($urandom_range(14, 1));
            if (above == 4'b0101 || above == 4'b1010)
                above = above ^ 4'b0001;
            for (int k = 0; k < 4; k++)
                v[k] = above[k] ? 8'($urandom_range(255, int'(iso_model) + 1))
                                : 8'($urandom_range(int'(iso_model), 0));
        end
        else if (pick < 90)
        begin
            for (int k = 0; k < 4; k++)
            begin
                case ($urandom_range(3))
                    0: v[k] = iso_model;
                    1: v[k] = 8'd0;
                    2: v[k] = 8'd255;
                    default: v[k] = 8'($urandom);
                endcase
            end
        end
        else
        begin
            plane = 2'($urandom_range(3));
            v = 32'($urandom);
        end
        return make_face(8'($urandom), 8'($urandom), 8'($urandom), plane,
                         v[0], v[1], v[2], v[3]);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every corner mask on rotating planes, plane three, corners exactly on
    // the level, the far grid corner, and both ends of the iso range.
    task automatic test_directed_cases();
        logic [3:0][7:0] v;
        logic [3:0] above;
        send_idle_pct = 37;
        recv_stall_pct = 84;
        // Reset level is still in force here.
        for (int m = 0; m < 16; m++)
        begin
            above = 4'(m);
            for (int k = 0; k < 4; k++)
                v[k] = above[k] ? 8'($urandom_range(255, 129)) : 8'($urandom_range(128, 0));
            send_face(make_face(8'($urandom), 8'($urandom), 8'($urandom), 2'(m % 3),
                                v[0], v[1], v[2], v[3]));
        end
        send_face(make_face(8'd4, 8'd5, 8'd6, 2'd3, 8'd200, 8'd10, 8'd10, 8'd10));
        // Corner on the level: zero fraction on one edge, a full step on the next.
        send_face(make_face(8'd0, 8'd0, 8'd0, PLANE_XY, 8'd128, 8'd255, 8'd128, 8'd128));
        // Far grid corner, reaching the top bit of the output coordinates.
        send_face(make_face(8'd255, 8'd255, 8'd255, PLANE_XY, 8'd255, 8'd0, 8'd0, 8'd128));
        send_face(make_face(8'd255, 8'd255, 8'd255, PLANE_YZ, 8'd255, 8'd0, 8'd0, 8'd128));
        send_face(make_face(8'd255, 8'd255, 8'd255, PLANE_ZX, 8'd255, 8'd0, 8'd0, 8'd128));
        wait_for_drain();
        set_iso(8'd0);
        send_face(make_face(8'd0, 8'd0, 8'd0, PLANE_YZ, 8'd0, 8'd1, 8'd0, 8'd0));
        send_face(make_face(8'd170, 8'd85, 8'd15, PLANE_ZX, 8'd255, 8'd255, 8'd255, 8'd0));
        wait_for_drain();
        set_iso(8'd255);
        send_face(make_face(8'd1, 8'd2, 8'd3, PLANE_XY, 8'd255, 8'd255, 8'd255, 8'd255));
        send_face(make_face(8'd9, 8'd8, 8'd7, PLANE_YZ, 8'd254, 8'd255, 8'd0, 8'd128));
        wait_for_drain();
    endtask

    // Random faces at a fresh iso level under the given idling mix.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int count);
        wait_for_drain();
        set_iso(8'($urandom_range(254, 1)));
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_face(random_face());
    endtask

    // Holds the result side off while faces keep coming until the block
    // stalls its input, pauses the sender until all segments are out, then sends more.
    task automatic test_input_backpressure();
        wait_for_drain();
        set_iso(8'd128);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        -> hold_start;
        repeat (60) send_face(random_face());
        wait_for_drain();
        repeat (20) send_face(random_face());
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_random_traffic(37, 84, 100);
        test_random_traffic(84, 37, 100);
        test_input_backpressure();
        test_random_traffic(0, 0, 100);
        wait_for_drain();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
src/msf_pkg.sv
src/msf_prep.sv
src/msf_div_stage.sv
src/msf_place.sv
src/marching_squares_face_segment.sv
dv/marching_squares_face_segment_test.sv
